@@ rtl/core/rational_arith_unit_core_defines.svh @@
// Assertion macros for the checker file of the rational arithmetic core.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef RATIONAL_ARITH_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/rau_pkg.sv @@
// Shared constants, opcodes, status codes and pipeline side-band type
// for the rational arithmetic core. No dependencies.
package rau_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int FIELD_W = 16;
	localparam int MODE_W = 3;
	localparam int NUM_W = 33;
	localparam int DEN_W = 32;
	localparam int ST_W = 2;

	localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
	localparam logic [MODE_W-1:0] MODE_GT  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_LT  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_EQ  = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSV = 3'd7;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_ZDEN = 2'd1;
	localparam logic [ST_W-1:0] ST_DIVZ = 2'd2;

	typedef struct packed {
		logic            zero;
		logic            num_neg;
		logic            den_neg;
		logic            cmp;
		logic [ST_W-1:0] status;
	} rau_meta_t;

endpackage

@@ rtl/core/rau_front.sv @@
// Front end: operand capture, cross products, sign/magnitude forming and compares.
// Depends on rau_pkg.
module rau_front import rau_pkg::*; #(
	parameter int OW = OPERAND_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      v_in,
	input  logic [MODE_W-1:0]         mode,
	input  logic signed [FIELD_W-1:0] a_num,
	input  logic signed [FIELD_W-1:0] a_den,
	input  logic signed [FIELD_W-1:0] b_num,
	input  logic signed [FIELD_W-1:0] b_den,
	output logic                      v_s3,
	output rau_meta_t                 meta_s3,
	output logic [2*OW-1:0]           nmag_s3,
	output logic [2*OW-1:0]           dmag_s3
);

	localparam int XW = (OW > FIELD_W) ? OW : FIELD_W;
	localparam int PW = 2 * OW;

	function automatic logic signed [OW-1:0] sx(input logic [FIELD_W-1:0] f);
		logic [XW-1:0] r;
		r = XW'(f);
		return signed'(r[OW-1:0]);
	endfunction

	logic                     v_s1, v_s2;
	logic [MODE_W-1:0]        mode_s1, mode_s2;
	logic signed [OW-1:0]     an_s1, ad_s1, bn_s1, bd_s1;
	logic signed [PW-1:0]     pa_s2, pb_s2, pd_s2;
	logic                     zden_s2, bz_s2, flip_s2;

	logic signed [OW-1:0]     ma, md;
	logic signed [PW:0]       nval, nabs, dabs;
	logic                     nneg, dneg;
	rau_meta_t                meta_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// multiplier operand select: mul takes b_num, div swaps b_num into the denominator
	assign ma = (mode_s1 == MODE_MUL) ? bn_s1 : bd_s1;
	assign md = (mode_s1 == MODE_DIV) ? bn_s1 : bd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			an_s1   <= sx(a_num);
			ad_s1   <= sx(a_den);
			bn_s1   <= sx(b_num);
			bd_s1   <= sx(b_den);

			mode_s2 <= mode_s1;
			pa_s2   <= PW'(an_s1) * PW'(ma);
			pb_s2   <= PW'(bn_s1) * PW'(ad_s1);
			pd_s2   <= PW'(ad_s1) * PW'(md);
			zden_s2 <= (ad_s1 == '0) || (bd_s1 == '0);
			bz_s2   <= (bn_s1 == '0);
			flip_s2 <= ad_s1[OW-1] ^ bd_s1[OW-1];

			meta_s3 <= meta_c;
			nmag_s3 <= meta_c.zero ? '0 : nabs[PW-1:0];
			dmag_s3 <= meta_c.zero ? '0 : dabs[PW-1:0];
		end
	end

	always_comb begin
		case (mode_s2)
			MODE_ADD: nval = (PW+1)'(pa_s2) + (PW+1)'(pb_s2);
			MODE_SUB: nval = (PW+1)'(pa_s2) - (PW+1)'(pb_s2);
			default:  nval = (PW+1)'(pa_s2);
		endcase
		nneg = nval[PW];
		nabs = nneg ? -nval : nval;
		dneg = pd_s2[PW-1];
		dabs = dneg ? -((PW+1)'(pd_s2)) : (PW+1)'(pd_s2);

		meta_c.zero    = 1'b1;
		meta_c.num_neg = nneg;
		meta_c.den_neg = dneg;
		meta_c.cmp     = 1'b0;
		meta_c.status  = ST_OK;
		case (mode_s2)
			MODE_ADD, MODE_SUB, MODE_MUL: meta_c.zero = 1'b0;
			MODE_DIV: begin
				if (bz_s2)
					meta_c.status = ST_DIVZ;
				else
					meta_c.zero = 1'b0;
			end
			// one negative denominator reverses the order of the cross products
			MODE_GT: meta_c.cmp = flip_s2 ? (pa_s2 < pb_s2) : (pa_s2 > pb_s2);
			MODE_LT: meta_c.cmp = flip_s2 ? (pa_s2 > pb_s2) : (pa_s2 < pb_s2);
			MODE_EQ: meta_c.cmp = (pa_s2 == pb_s2);
			default: meta_c.zero = 1'b1;
		endcase
		if (zden_s2 && (mode_s2 != MODE_RSV)) begin
			meta_c.zero   = 1'b1;
			meta_c.cmp    = 1'b0;
			meta_c.status = ST_ZDEN;
		end
	end

endmodule

@@ rtl/core/rau_gcd.sv @@
// Pipelined binary gcd: one Stein step per stage, then the common power of two
// is restored. Depends on rau_pkg.
module rau_gcd import rau_pkg::*; #(
	parameter int MW = 2 * OPERAND_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  rau_meta_t     meta_in,
	input  logic [MW-1:0] nmag_in,
	input  logic [MW-1:0] dmag_in,
	output logic          v_sg,
	output rau_meta_t     meta_sg,
	output logic [MW-1:0] nmag_sg,
	output logic [MW-1:0] dmag_sg,
	output logic [MW-1:0] g_sg
);

	// every step shrinks the combined bit length by one, so 2*MW steps finish
	localparam int NS = 2 * MW;
	localparam int KW = $clog2(MW + 1);

	logic          v_s [NS+1];
	logic [MW-1:0] x_s [NS+1];
	logic [MW-1:0] y_s [NS+1];
	logic [MW-1:0] n_s [NS+1];
	logic [MW-1:0] d_s [NS+1];
	logic [KW-1:0] k_s [NS+1];
	rau_meta_t     m_s [NS+1];

	logic [MW-1:0] gz, gs;

	assign v_s[0] = v_in;
	assign x_s[0] = nmag_in;
	assign y_s[0] = dmag_in;
	assign n_s[0] = nmag_in;
	assign d_s[0] = dmag_in;
	assign k_s[0] = '0;
	assign m_s[0] = meta_in;

	for (genvar i = 0; i < NS; i++) begin : g_step
		logic [MW-1:0] nx, ny;
		logic [KW-1:0] nk;

		always_comb begin
			nx = x_s[i];
			ny = y_s[i];
			nk = k_s[i];
			if ((x_s[i] != '0) && (y_s[i] != '0)) begin
				if (!x_s[i][0] && !y_s[i][0]) begin
					nx = x_s[i] >> 1;
					ny = y_s[i] >> 1;
					nk = KW'(k_s[i] + 1'b1);
				end else if (!x_s[i][0]) begin
					nx = x_s[i] >> 1;
				end else if (!y_s[i][0]) begin
					ny = y_s[i] >> 1;
				end else if (x_s[i] >= y_s[i]) begin
					nx = (x_s[i] - y_s[i]) >> 1;
				end else begin
					ny = (y_s[i] - x_s[i]) >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1] <= nx;
				y_s[i+1] <= ny;
				k_s[i+1] <= nk;
				n_s[i+1] <= n_s[i];
				d_s[i+1] <= d_s[i];
				m_s[i+1] <= m_s[i];
			end
		end
	end

	// one side is zero now; the other carries the odd part of the gcd
	assign gz = x_s[NS] | y_s[NS];
	assign gs = gz << k_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sg <= 1'b0;
		else if (en)
			v_sg <= v_s[NS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_sg    <= (gs == '0) ? MW'(1) : gs;
			nmag_sg <= n_s[NS];
			dmag_sg <= d_s[NS];
			meta_sg <= m_s[NS];
		end
	end

endmodule

@@ rtl/core/rau_div.sv @@
// Twin restoring dividers sharing one divisor: one quotient bit per stage
// for numerator and denominator. Depends on rau_pkg.
module rau_div import rau_pkg::*; #(
	parameter int MW = 2 * OPERAND_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  rau_meta_t     meta_in,
	input  logic [MW-1:0] nmag_in,
	input  logic [MW-1:0] dmag_in,
	input  logic [MW-1:0] g_in,
	output logic          v_out,
	output rau_meta_t     meta_out,
	output logic [MW-1:0] nq_out,
	output logic [MW-1:0] dq_out
);

	logic          v_s  [MW+1];
	logic [MW:0]   rn_s [MW+1];
	logic [MW:0]   rd_s [MW+1];
	logic [MW-1:0] qn_s [MW+1];
	logic [MW-1:0] qd_s [MW+1];
	logic [MW-1:0] g_s  [MW+1];
	rau_meta_t     m_s  [MW+1];

	assign v_s[0]  = v_in;
	assign rn_s[0] = '0;
	assign rd_s[0] = '0;
	assign qn_s[0] = nmag_in;
	assign qd_s[0] = dmag_in;
	assign g_s[0]  = g_in;
	assign m_s[0]  = meta_in;

	for (genvar i = 0; i < MW; i++) begin : g_bit
		logic [MW:0] tn, td, gx;
		logic        bn, bd;

		// shift the next dividend bit into the partial remainder
		always_comb begin
			gx = {1'b0, g_s[i]};
			tn = {rn_s[i][MW-1:0], qn_s[i][MW-1]};
			td = {rd_s[i][MW-1:0], qd_s[i][MW-1]};
			bn = (tn >= gx);
			bd = (td >= gx);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rn_s[i+1] <= bn ? (tn - gx) : tn;
				rd_s[i+1] <= bd ? (td - gx) : td;
				qn_s[i+1] <= {qn_s[i][MW-2:0], bn};
				qd_s[i+1] <= {qd_s[i][MW-2:0], bd};
				g_s[i+1]  <= g_s[i];
				m_s[i+1]  <= m_s[i];
			end
		end
	end

	assign v_out    = v_s[MW];
	assign meta_out = m_s[MW];
	assign nq_out   = qn_s[MW];
	assign dq_out   = qd_s[MW];

endmodule

@@ rtl/core/rational_arith_unit_core.sv @@
// Rational arithmetic core: add, sub, mul, div and compare on two signed fractions,
// with the result reduced by the gcd of its magnitudes.
// Input channel item_valid/item_stall carries mode and the four operands; output
// channel res_valid/res_stall carries res_num, res_den, cmp_true and status.
// A word is taken at a clock edge with valid high and stall low.
// Fully pipelined: one word per cycle in and out while no output word is stalled.
// The pipeline, in order: three front stages, 4*OPERAND_WIDTH binary gcd steps,
// one gcd fix-up stage, 2*OPERAND_WIDTH quotient-bit stages of the dividers and
// the output register.
// The gcd chain is the longest part; its depth follows the product width.
// When the receiver stalls a waiting word, the whole pipe holds and item_stall
// rises in the same cycle; nothing is dropped or repeated.
// Reset (arst_n low) clears every valid bit at once; words in flight are lost.
// Errors and compares come out with zero numerator and denominator.
// Depends on rau_pkg, rau_front, rau_gcd, rau_div.
module rational_arith_unit_core import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [MODE_W-1:0]         mode,
	input  logic signed [FIELD_W-1:0] a_num,
	input  logic signed [FIELD_W-1:0] a_den,
	input  logic signed [FIELD_W-1:0] b_num,
	input  logic signed [FIELD_W-1:0] b_den,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic signed [NUM_W-1:0]   res_num,
	output logic signed [DEN_W-1:0]   res_den,
	output logic                      cmp_true,
	output logic [ST_W-1:0]           status
);

	localparam int MW = 2 * OPERAND_WIDTH;
	localparam int SW = (MW + 1 > NUM_W) ? MW + 1 : NUM_W;

	logic          en;
	logic          v_f, v_g, v_d;
	rau_meta_t     meta_f, meta_g, meta_d;
	logic [MW-1:0] nmag_f, dmag_f, nmag_g, dmag_g, g_g, nq_d, dq_d;

	logic signed [MW:0]   nsv, dsv;
	logic signed [SW-1:0] nx, dx;

	// advance unless the output word is held
	assign en         = !(res_valid && res_stall);
	assign item_stall = !en;

	rau_front #(.OW(OPERAND_WIDTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (item_valid),
		.mode    (mode),
		.a_num   (a_num),
		.a_den   (a_den),
		.b_num   (b_num),
		.b_den   (b_den),
		.v_s3    (v_f),
		.meta_s3 (meta_f),
		.nmag_s3 (nmag_f),
		.dmag_s3 (dmag_f)
	);

	rau_gcd #(.MW(MW)) u_gcd (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_f),
		.meta_in (meta_f),
		.nmag_in (nmag_f),
		.dmag_in (dmag_f),
		.v_sg    (v_g),
		.meta_sg (meta_g),
		.nmag_sg (nmag_g),
		.dmag_sg (dmag_g),
		.g_sg    (g_g)
	);

	rau_div #(.MW(MW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_g),
		.meta_in  (meta_g),
		.nmag_in  (nmag_g),
		.dmag_in  (dmag_g),
		.g_in     (g_g),
		.v_out    (v_d),
		.meta_out (meta_d),
		.nq_out   (nq_d),
		.dq_out   (dq_d)
	);

	always_comb begin
		nsv = meta_d.num_neg ? -signed'({1'b0, nq_d}) : signed'({1'b0, nq_d});
		dsv = meta_d.den_neg ? -signed'({1'b0, dq_d}) : signed'({1'b0, dq_d});
		nx  = SW'(nsv);
		dx  = SW'(dsv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else if (en)
			res_valid <= v_d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_num  <= meta_d.zero ? '0 : nx[NUM_W-1:0];
			res_den  <= meta_d.zero ? '0 : dx[DEN_W-1:0];
			cmp_true <= meta_d.cmp;
			status   <= meta_d.status;
		end
	end

endmodule

@@ rtl/core/rau_chk.sv @@
// Port-level checker for the rational arithmetic core, bound to the top level.
// Depends on rau_pkg and rational_arith_unit_core_defines.svh.
`include "rational_arith_unit_core_defines.svh"

module rau_chk import rau_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_stall,
	input logic                    res_valid,
	input logic                    res_stall,
	input logic signed [NUM_W-1:0] res_num,
	input logic signed [DEN_W-1:0] res_den,
	input logic                    cmp_true,
	input logic [ST_W-1:0]         status
);

	`RAU_ASSERT_NXT(a_hold_valid, res_valid && res_stall, res_valid, "held word lost valid")
	`RAU_ASSERT_NXT(a_hold_data, res_valid && res_stall, $stable(res_num) && $stable(res_den) && $stable(cmp_true) && $stable(status), "held word changed")
	`RAU_ASSERT_IMP(a_back_press, res_valid && res_stall, item_stall, "input taken while output held")
	`RAU_ASSERT_IMP(a_err_zero, res_valid && (status != ST_OK), (res_num == '0) && (res_den == '0) && !cmp_true, "error word not cleared")
	`RAU_ASSERT_IMP(a_cmp_zero, res_valid && cmp_true, (status == ST_OK) && (res_num == '0) && (res_den == '0), "compare word carries a value")

endmodule

bind rational_arith_unit_core rau_chk u_chk (.*);
